// File: hw/rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// Huffman delta sample decoder package
// Shared widths, the queue entry type and the bit-scan helpers used by the
// front and back parts of the decoder.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int WORD_W         = 16;
  localparam int REM_W          = 15;
  localparam int MAX_CODE_ZEROS = 6;

  // Class of a queued word, decided by the front part.
  typedef enum logic [1:0] {
    KIND_EXPLICIT = 2'd0,
    KIND_CODED    = 2'd1,
    KIND_MARKER   = 2'd2
  } hds_kind_t;

  // One queued word: its class, the channel-start flag and either the
  // explicit sample or the code bits that follow the start marker.
  typedef struct packed {
    hds_kind_t          kind;
    logic               start;
    logic [REM_W-1:0]   data;
  } hds_entry_t;

  // Position of the lowest set bit of a 15-bit value (0 when none is set).
  function automatic logic [3:0] lowest_one15(input logic [REM_W-1:0] bits);
    logic [3:0] pos;
    pos = '0;
    for (int i = REM_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

  // Position of the lowest set bit of a 16-bit word (0 when none is set).
  function automatic logic [3:0] lowest_one16(input logic [WORD_W-1:0] bits);
    logic [3:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: hw/rtl/hds_word_if.sv
// ----------------------------------------------------------------------------
// Input word channel
// Valid/ready channel that carries one raw waveform word per transaction.
// ----------------------------------------------------------------------------
interface hds_word_if;
  logic                         valid;
  logic                         ready;
  logic [hds_pkg::WORD_W-1:0]   raw_word;
  logic                         channel_start;

  modport source (output valid, output raw_word, output channel_start, input ready);
  modport sink   (input valid, input raw_word, input channel_start, output ready);
endinterface

// File: hw/rtl/hds_sample_if.sv
// ----------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel that carries one decoded sample per transaction.
// ----------------------------------------------------------------------------
interface hds_sample_if;
  logic                         valid;
  logic                         ready;
  logic [hds_pkg::WORD_W-1:0]   sample;
  logic                         bad_pattern;
  logic                         last_of_word;

  modport source (output valid, output sample, output bad_pattern,
                  output last_of_word, input ready);
  modport sink   (input valid, input sample, input bad_pattern,
                  input last_of_word, output ready);
endinterface

// File: hw/rtl/hds_front.sv
// ----------------------------------------------------------------------------
// Decoder front part
// Accepts raw words, classifies them and strips the padding and start marker
// from coded words before handing them to the queue.
// ----------------------------------------------------------------------------
module hds_front (
  input  logic                   clk,
  input  logic                   rst,
  hds_word_if.sink               word_ch,
  output logic                   push_valid,
  input  logic                   push_ready,
  output hds_pkg::hds_entry_t    push_data
);
  import hds_pkg::*;

  logic        stage_valid;
  hds_entry_t  stage_entry;
  hds_entry_t  classified;
  logic [3:0]  marker_pos;
  logic [REM_W-1:0] code_bits;

  // A word is taken whenever the stage is empty or drains this cycle.
  assign word_ch.ready = !stage_valid || push_ready;
  assign push_valid    = stage_valid;
  assign push_data     = stage_entry;

  // Classify the word and keep only the bits above the start marker.
  always_comb begin
    marker_pos = lowest_one16(word_ch.raw_word);
    code_bits  = REM_W'(word_ch.raw_word >> (5'(marker_pos) + 5'd1));
    classified.start = word_ch.channel_start;
    if (!word_ch.raw_word[WORD_W-1]) begin
      classified.kind = KIND_EXPLICIT;
      classified.data = word_ch.raw_word[REM_W-1:0];
    end else if (code_bits == '0) begin
      classified.kind = KIND_MARKER;
      classified.data = '0;
    end else begin
      classified.kind = KIND_CODED;
      classified.data = code_bits;
    end
  end

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (word_ch.valid && word_ch.ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (word_ch.valid && word_ch.ready) begin
      stage_entry <= classified;
    end
  end

endmodule

// File: hw/rtl/hds_queue.sv
// ----------------------------------------------------------------------------
// Decoder word queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module hds_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  hds_pkg::hds_entry_t    push_data,
  output logic                   pop_valid,
  input  logic                   pop,
  output hds_pkg::hds_entry_t    pop_data
);
  import hds_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hds_entry_t        entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/hds_back.sv
// ----------------------------------------------------------------------------
// Decoder back part
// Takes classified words from the queue, decodes one code per cycle against
// the last sample unless the output stalls, and feeds the registered output.
// ----------------------------------------------------------------------------
module hds_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop,
  input  hds_pkg::hds_entry_t    pop_data,
  hds_sample_if.source           sample_ch
);
  import hds_pkg::*;

  logic              busy;
  logic              busy_next;
  logic [REM_W-1:0]  work_rem;
  logic [REM_W-1:0]  work_rem_next;
  logic [WORD_W-1:0] last_sample;
  logic [WORD_W-1:0] last_sample_next;

  logic              out_valid;
  logic [WORD_W-1:0] out_sample;
  logic              out_bad;
  logic              out_last;

  logic              advance;
  logic              step;
  logic              emit;
  logic [WORD_W-1:0] emit_sample;
  logic              emit_bad;
  logic              emit_last;

  hds_kind_t         cur_kind;
  logic [REM_W-1:0]  cur_rem;
  logic [WORD_W-1:0] base;
  logic [3:0]        zeros;
  logic              bad_code;
  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] coded_sample;
  logic [REM_W-1:0]  rem_after;

  assign sample_ch.valid        = out_valid;
  assign sample_ch.sample       = out_sample;
  assign sample_ch.bad_pattern  = out_bad;
  assign sample_ch.last_of_word = out_last;

  // The output register can take a new result when empty or being drained.
  assign advance = !out_valid || sample_ch.ready;
  assign step    = advance && (busy || pop_valid);
  assign pop     = step && !busy;

  // Current work: the rest of a word in progress, or the queue head.
  always_comb begin
    if (busy) begin
      cur_kind = KIND_CODED;
      cur_rem  = work_rem;
      base     = last_sample;
    end else begin
      cur_kind = pop_data.kind;
      cur_rem  = pop_data.data;
      base     = pop_data.start ? '0 : last_sample;
    end
  end

  // Decode the lowest code: its zero count selects the delta.
  always_comb begin
    zeros        = lowest_one15(cur_rem);
    bad_code     = (zeros > 4'(MAX_CODE_ZEROS));
    mag          = WORD_W'((5'(zeros) + 5'd1) >> 1);
    coded_sample = zeros[0] ? base - mag : base + mag;
    rem_after    = cur_rem >> (5'(zeros) + 5'd1);
  end

  // Result selection and next state.
  always_comb begin
    emit             = 1'b0;
    emit_sample      = '0;
    emit_bad         = 1'b0;
    emit_last        = 1'b0;
    busy_next        = busy;
    work_rem_next    = work_rem;
    last_sample_next = last_sample;
    if (step) begin
      unique case (cur_kind)
        KIND_EXPLICIT: begin
          emit             = 1'b1;
          emit_sample      = {1'b0, cur_rem};
          emit_last        = 1'b1;
          last_sample_next = {1'b0, cur_rem};
          busy_next        = 1'b0;
        end
        KIND_MARKER: begin
          last_sample_next = base;
          busy_next        = 1'b0;
        end
        KIND_CODED: begin
          emit = 1'b1;
          if (bad_code) begin
            emit_bad         = 1'b1;
            emit_last        = 1'b1;
            last_sample_next = base;
            busy_next        = 1'b0;
          end else begin
            emit_sample      = coded_sample;
            emit_last        = (rem_after == '0);
            last_sample_next = coded_sample;
            busy_next        = (rem_after != '0);
            work_rem_next    = rem_after;
          end
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      last_sample <= '0;
      out_valid   <= 1'b0;
    end else begin
      busy        <= busy_next;
      last_sample <= last_sample_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    work_rem <= work_rem_next;
    if (advance && emit) begin
      out_sample <= emit_sample;
      out_bad    <= emit_bad;
      out_last   <= emit_last;
    end
  end

endmodule

// File: hw/rtl/huffman_delta_sample_decoder.sv
// ----------------------------------------------------------------------------
// Huffman delta sample decoder
// Decodes 16-bit waveform words, explicit or Huffman-coded deltas, into a
// stream of samples.
//
//   Channel     Role    Transaction payload
//   word_ch     sink    raw_word[15:0], channel_start
//   sample_ch   source  sample[15:0], bad_pattern, last_of_word
//
// The single code decoder in the back part takes one code of a coded word
// at a time and emits one sample per cycle while the output is not
// stalled; an explicit word gives one sample, a marker-only word none.
// A word passes the front register, the queue and the output register
// before its first sample. The queue holds QUEUE_DEPTH words so the front
// keeps taking words while the back decodes or the output stalls.
// Reset clears the last sample to zero and empties all stages.
// ----------------------------------------------------------------------------
module huffman_delta_sample_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  hds_word_if.sink      word_ch,
  hds_sample_if.source  sample_ch
);
  import hds_pkg::*;

  logic        push_valid;
  logic        push_ready;
  hds_entry_t  push_data;
  logic        pop_valid;
  logic        pop;
  hds_entry_t  pop_data;

  // Accept and classify words.
  hds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .word_ch    (word_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Buffer classified words.
  hds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  // Decode and emit samples.
  hds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .sample_ch (sample_ch)
  );

endmodule

// File: sim/tb_huffman_delta_sample_decoder.sv
// ----------------------------------------------------------------------------
// Huffman delta sample decoder testbench
// Feeds waveform words to the decoder: first a table of corner-case words,
// then random words, mostly well-formed code sequences. A behavioral decoder
// predicts the samples of random words and untyped rows; every sample is
// checked field by field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_huffman_delta_sample_decoder;
  import hds_pkg::*;

  localparam int CODED_BIT    = WORD_W - 1;
  localparam int MAX_RESULTS  = WORD_W - 1;
  localparam int RANDOM_WORDS = 156;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int TABLE_ROWS   = 24;

  // One decoded sample as it leaves the block.
  typedef struct packed {
    logic [WORD_W-1:0] sample;
    logic              bad_pattern;
    logic              last_of_word;
  } sample_rec_t;

  // One row of the directed table; typed rows carry their single result.
  typedef struct packed {
    logic [WORD_W-1:0] raw_word;
    logic              channel_start;
    logic              typed;
    sample_rec_t       result;
  } word_row_t;

  // Ready patterns of the sample receiver.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PATTERN
  } ready_mode_t;

  logic clk;
  logic rst;

  hds_word_if   word_ch();
  hds_sample_if sample_ch();

  huffman_delta_sample_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .word_ch   (word_ch),
    .sample_ch (sample_ch)
  );

  sample_rec_t       pending_samples[$];
  logic [WORD_W-1:0] held_sample;
  int                mismatches  = 0;
  int                cycle_count = 0;
  int                burst_left  = 0;

  // Corner-case words. Typed rows hold a result that follows directly from
  // the word; the other rows are checked against the behavioral decoder.
  word_row_t directed_rows [TABLE_ROWS] = '{
    '{16'hC000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1}}, // zero delta right after reset
    '{16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1}}, // smallest explicit sample
    '{16'h7FFF, 1'b0, 1'b1, '{16'h7FFF, 1'b0, 1'b1}}, // largest explicit sample
    '{16'h1234, 1'b1, 1'b1, '{16'h1234, 1'b0, 1'b1}}, // explicit with channel start
    '{16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{16'hA000, 1'b0, 1'b1, '{16'hFFFF, 1'b0, 1'b1}}, // minus one wraps below zero
    '{16'h8100, 1'b0, 1'b0, '0},                      // plus three wraps past the top
    '{16'hFFFF, 1'b0, 1'b0, '0},                      // fifteen zero-delta codes
    '{16'h8080, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}}, // seven zeros is a bad code
    '{16'h8001, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}}, // fourteen zeros
    '{16'h8003, 1'b0, 1'b0, '0},                      // good code, then a bad one
    '{16'h8000, 1'b0, 1'b0, '0},                      // start marker only
    '{16'h8000, 1'b1, 1'b0, '0},                      // marker only with channel start
    '{16'hC000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1}}, // the marker word cleared the sample
    '{16'h7FFE, 1'b0, 1'b1, '{16'h7FFE, 1'b0, 1'b1}},
    '{16'h8421, 1'b0, 1'b0, '0},                      // plus two, three times
    '{16'h9249, 1'b0, 1'b0, '0},                      // plus one, five times
    '{16'hAAAB, 1'b0, 1'b0, '0},                      // zero, then minus one seven times
    '{16'hD555, 1'b0, 1'b0, '0},                      // minus one seven times, then zero
    '{16'hA000, 1'b1, 1'b1, '{16'hFFFF, 1'b0, 1'b1}}, // channel start, then minus one
    '{16'h8100, 1'b1, 1'b1, '{16'h0003, 1'b0, 1'b1}}, // channel start, then plus three
    '{16'h8200, 1'b0, 1'b0, '0},                      // minus three
    '{16'h5555, 1'b0, 1'b1, '{16'h5555, 1'b0, 1'b1}},
    '{16'h8040, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1}}  // eight zeros with channel start
  };

  // Clock with a period of ten time units.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral decoder: fills recs with the samples of one word, updates the
  // held sample and returns the number of samples.
  function automatic int decode_word(input logic [WORD_W-1:0] word, input logic start,
                                     output sample_rec_t recs [MAX_RESULTS]);
    int                n;
    int                zeros;
    logic              seen;
    logic [WORD_W-1:0] step;
    n     = 0;
    zeros = 0;
    seen  = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      recs[i] = '0;
    end
    if (start) begin
      held_sample = '0;
    end
    // An explicit word replaces the held sample outright.
    if (!word[CODED_BIT]) begin
      held_sample = {1'b0, word[REM_W-1:0]};
      recs[0]     = '{held_sample, 1'b0, 1'b1};
      return 1;
    end
    // Scan from the low end: padding, the start marker, then the codes.
    for (int i = 0; i < WORD_W; i++) begin
      if (!word[i]) begin
        if (seen) begin
          zeros++;
        end
      end else if (!seen) begin
        seen = 1'b1;
      end else if (zeros > MAX_CODE_ZEROS) begin
        recs[n] = '{'0, 1'b1, 1'b1};
        return n + 1;
      end else begin
        step        = WORD_W'((zeros + 1) / 2);
        held_sample = (zeros % 2 == 1) ? held_sample - step : held_sample + step;
        recs[n]     = '{held_sample, 1'b0, 1'b0};
        n++;
        zeros = 0;
      end
    end
    if (n > 0) begin
      recs[n-1].last_of_word = 1'b1;
    end
    return n;
  endfunction

  // Sends one word in bursts with random gaps, then queues its samples once
  // the transaction has taken place.
  task automatic send_word(input logic [WORD_W-1:0] word, input logic start,
                           input logic typed, input sample_rec_t typed_rec);
    sample_rec_t recs [MAX_RESULTS];
    int          n;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      word_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    word_ch.valid         <= 1'b1;
    word_ch.raw_word      <= word;
    word_ch.channel_start <= start;
    do @(posedge clk); while (!word_ch.ready);
    n = decode_word(word, start, recs);
    if (typed) begin
      pending_samples = {pending_samples, typed_rec};
    end else begin
      for (int i = 0; i < n; i++) begin
        pending_samples = {pending_samples, recs[i]};
      end
    end
    burst_left--;
    @(negedge clk);
  endtask

  // Sample receiver: ready follows a mode that is picked anew at random.
  initial begin : sample_receiver
    ready_mode_t mode;
    int          mode_left;
    logic [7:0]  pattern;
    mode              = READY_ALWAYS;
    mode_left         = 0;
    pattern           = 8'hFF;
    sample_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
        pattern   = 8'($urandom);
      end else begin
        mode_left--;
      end
      pattern = {pattern[6:0], pattern[7]};
      case (mode)
        READY_ALWAYS: sample_ch.ready <= 1'b1;
        READY_MOSTLY: sample_ch.ready <= ($urandom_range(0, 3) != 0);
        READY_RARELY: sample_ch.ready <= ($urandom_range(0, 3) == 0);
        default:      sample_ch.ready <= pattern[0];
      endcase
    end
  end

  // Compare every sample transaction with the oldest pending prediction.
  always @(posedge clk) begin : sample_check
    sample_rec_t want;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected sample transaction: sample=%h bad=%b last=%b",
                   sample_ch.sample, sample_ch.bad_pattern, sample_ch.last_of_word);
        end
      end else begin
        want = pending_samples.pop_front();
        if (sample_ch.sample !== want.sample || sample_ch.bad_pattern !== want.bad_pattern ||
            sample_ch.last_of_word !== want.last_of_word) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("sample mismatch: expected sample=%h bad=%b last=%b,",
                     want.sample, want.bad_pattern, want.last_of_word,
                     " got sample=%h bad=%b last=%b",
                     sample_ch.sample, sample_ch.bad_pattern, sample_ch.last_of_word);
          end
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("huffman_delta_sample_decoder test failed");
      $finish;
    end
  end

  // Reset, directed table, random words, drain and verdict.
  initial begin : word_source
    logic [WORD_W-1:0] word;
    logic              start;
    int                pick;
    int                marker;
    int                pos;
    int                zeros;
    int                run;
    rst                   = 1'b1;
    word_ch.valid         = 1'b0;
    word_ch.raw_word      = '0;
    word_ch.channel_start = 1'b0;
    held_sample           = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < TABLE_ROWS; r++) begin
      send_word(directed_rows[r].raw_word, directed_rows[r].channel_start,
                directed_rows[r].typed, directed_rows[r].result);
    end

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick  = $urandom_range(0, 19);
      start = ($urandom_range(0, 7) == 0);
      if (pick <= 10) begin
        // Well-formed coded word: marker, then codes that end on the top bit.
        marker = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 3);
        word         = '0;
        word[marker] = 1'b1;
        pos          = marker + 1;
        while (pos <= CODED_BIT) begin
          zeros = $urandom_range(0, MAX_CODE_ZEROS);
          if (pos + zeros >= CODED_BIT) begin
            zeros = CODED_BIT - pos;
          end
          word[pos+zeros] = 1'b1;
          pos = pos + zeros + 1;
        end
      end else if (pick <= 13) begin
        word            = WORD_W'($urandom);
        word[CODED_BIT] = 1'b0;
      end else if (pick <= 16) begin
        word = WORD_W'($urandom);
      end else if (pick <= 18) begin
        // Broken word: the first code after the marker is too long.
        marker = $urandom_range(0, 7);
        run    = $urandom_range(7, CODED_BIT - 1 - marker);
        word   = WORD_W'($urandom);
        for (int i = 0; i < marker; i++) begin
          word[i] = 1'b0;
        end
        word[marker] = 1'b1;
        for (int i = marker + 1; i <= marker + run; i++) begin
          word[i] = 1'b0;
        end
        word[CODED_BIT] = 1'b1;
      end else begin
        word            = '0;
        word[CODED_BIT] = 1'b1;
      end
      send_word(word, start, 1'b0, '0);
    end
    word_ch.valid <= 1'b0;

    // Wait for every predicted sample, then give the block time to misbehave.
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("huffman_delta_sample_decoder test passed");
    end else begin
      $display("huffman_delta_sample_decoder test failed");
    end
    $finish;
  end

endmodule
